### design/dither_threshold_matrix_generator_defines.svh
// Assertion macros shared by the dither threshold matrix generator.
`ifndef DITHER_THRESHOLD_MATRIX_GENERATOR_DEFINES_SVH
`define DITHER_THRESHOLD_MATRIX_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while arst_n is low.
`define DTM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk and disabled while arst_n is low.
`define DTM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/dtm_pkg.sv
// Types, constants and the position table of the dither threshold matrix generator.
package dtm_pkg;

	localparam int unsigned LevelW     = 8;
	localparam int unsigned LevelCount = 4;
	localparam int unsigned ChanCount  = 3;
	localparam int unsigned SlotCount  = 16;
	localparam int unsigned EntryCount = 48;
	localparam int unsigned IndexW     = 6;
	localparam int unsigned ChanW      = 2;
	localparam int unsigned SlotW      = 4;
	localparam int unsigned PosW       = 4;

	localparam logic [LevelW-1:0] LevelMax  = 8'd255;
	localparam logic [IndexW-1:0] LastIndex = IndexW'(EntryCount - 1);
	localparam logic [ChanW-1:0]  LastChan  = ChanW'(ChanCount - 1);

	typedef struct packed {
		logic [7:0] slope;
		logic [7:0] offset;
	} dtm_req_t;

	typedef struct packed {
		logic [5:0] entry_index;
		logic [7:0] threshold;
		logic       last_entry;
	} dtm_res_t;

	typedef logic [LevelCount-1:0][LevelW-1:0] dtm_levels_t;

	// Pixel position of each matrix slot; the inverse of the slot offsets
	// 0,30,24,6 / 15,45,39,21 / 12,42,36,18 / 3,33,27,9 divided by three.
	function automatic logic [PosW-1:0] slot_to_pos(input logic [SlotW-1:0] slot);
		logic [PosW-1:0] pos;
		unique case (slot)
			4'd0:    pos = 4'd0;
			4'd1:    pos = 4'd12;
			4'd2:    pos = 4'd3;
			4'd3:    pos = 4'd15;
			4'd4:    pos = 4'd8;
			4'd5:    pos = 4'd4;
			4'd6:    pos = 4'd11;
			4'd7:    pos = 4'd7;
			4'd8:    pos = 4'd2;
			4'd9:    pos = 4'd14;
			4'd10:   pos = 4'd1;
			4'd11:   pos = 4'd13;
			4'd12:   pos = 4'd10;
			4'd13:   pos = 4'd6;
			4'd14:   pos = 4'd9;
			default: pos = 4'd5;
		endcase
		return pos;
	endfunction

endpackage

### design/dither_threshold_matrix_generator.sv
// Top level of the dither threshold matrix generator: sequencer and result register.
//
// A request (slope, offset) is accepted at a rising edge where start is high
// and busy is low. The four quantization levels are registered at that edge.
// The block then walks the 48 matrix entries, one per cycle, computing each
// threshold from the registered levels and loading it into the result register.
// Each entry appears on result for exactly one cycle with result_valid high,
// in index order 0 to 47; last_entry marks index 47.
// The first entry passes through the sequencer registers and then the result
// register before it reaches the ports. The entry counter emits one entry per
// cycle; busy drops during the cycle that computes index 47, so a new request
// can follow with no gap between runs.
// The receiver cannot stall; results are taken as they appear.
// Reset clears the sequencer and the result strobe; no run is in progress after it.
module dither_threshold_matrix_generator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  dtm_pkg::dtm_req_t req,
	output logic              result_valid,
	output dtm_pkg::dtm_res_t result
);
	import dtm_pkg::*;

	logic                active_q;
	logic [IndexW-1:0]   index_q;
	logic [ChanW-1:0]    chan_q;
	logic [SlotW-1:0]    slot_q;
	dtm_levels_t         levels_q;
	dtm_levels_t         levels_next;
	logic [LevelW-1:0]   threshold;
	logic                accept;
	logic                valid_s1;
	dtm_res_t            result_s1;

	assign busy   = active_q && (index_q != LastIndex);
	assign accept = start && !busy;

	dtm_levels u_levels (
		.req    (req),
		.levels (levels_next)
	);

	dtm_interp u_interp (
		.levels    (levels_q),
		.chan      (chan_q),
		.slot      (slot_q),
		.threshold (threshold)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			levels_q <= levels_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			index_q  <= '0;
			chan_q   <= '0;
			slot_q   <= '0;
		end else if (accept) begin
			active_q <= 1'b1;
			index_q  <= '0;
			chan_q   <= '0;
			slot_q   <= '0;
		end else if (active_q) begin
			if (index_q == LastIndex) begin
				active_q <= 1'b0;
			end else begin
				index_q <= index_q + 1'b1;
				if (chan_q == LastChan) begin
					chan_q <= '0;
					slot_q <= slot_q + 1'b1;
				end else begin
					chan_q <= chan_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= active_q;
		end
	end

	always_ff @(posedge clk) begin
		if (active_q) begin
			result_s1.entry_index <= index_q;
			result_s1.threshold   <= threshold;
			result_s1.last_entry  <= (index_q == LastIndex);
		end
	end

	assign result_valid = valid_s1;
	assign result       = result_s1;

`include "dither_threshold_matrix_generator_defines.svh"

	// The first entry of a run follows its transaction through the sequencer and result registers.
	`DTM_ASSERT_NOW(a_first_after_accept, result_valid && (result.entry_index == '0), $past(start && !busy, 2), "first entry without a matching transaction")
	// Entries within a run follow each other with no gap and in index order.
	`DTM_ASSERT_NEXT(a_index_in_order, result_valid && !result.last_entry, result_valid && (result.entry_index == IndexW'($past(result.entry_index) + 1'b1)), "entry index out of order")
	// While busy, an entry is being computed and must appear in the next cycle.
	`DTM_ASSERT_NEXT(a_busy_emits, busy, result_valid, "busy without an emitted entry")

endmodule

### design/dtm_levels.sv
// Quantization level builder: offset plus k times slope, saturated at 255.
module dtm_levels (
	input  dtm_pkg::dtm_req_t    req,
	output dtm_pkg::dtm_levels_t levels
);
	import dtm_pkg::*;

	localparam int unsigned SumW = LevelW + 2;

	always_comb begin
		logic [SumW-1:0] sum;
		for (int k = 0; k < LevelCount; k++) begin
			sum = SumW'(req.offset) + SumW'(k) * SumW'(req.slope);
			levels[k] = (sum > SumW'(LevelMax)) ? LevelMax : sum[LevelW-1:0];
		end
	end

endmodule

### design/dtm_interp.sv
// Threshold interpolation between two adjacent levels in 8.4 fixed point.
module dtm_interp (
	input  dtm_pkg::dtm_levels_t levels,
	input  logic [1:0]           chan,
	input  logic [3:0]           slot,
	output logic [7:0]           threshold
);
	import dtm_pkg::*;

	localparam int unsigned AccW = LevelW + PosW + 1;

	logic [LevelW-1:0] base;
	logic [LevelW-1:0] step;
	logic [PosW-1:0]   pos;
	logic [AccW-1:0]   acc;

	always_comb begin
		base = levels[chan];
		// Levels never decrease, so the step is never negative.
		step = levels[ChanW'(chan + 2'd1)] - base;
		pos  = slot_to_pos(slot);
		acc  = {1'b0, base, {PosW{1'b0}}} + AccW'(pos) * AccW'(step);
		threshold = acc[PosW +: LevelW];
	end

endmodule

### bench/testbench.sv
// Self-checking testbench for the dither threshold matrix generator.
`timescale 1ns / 1ps

module testbench;
	import dtm_pkg::*;

	localparam int unsigned LevelLimit   = 256;
	localparam int unsigned RandomCount  = 200;
	localparam int unsigned StallLimit   = 1000;
	localparam int unsigned DrainCycles  = 8;
	localparam int unsigned DirectedRows = 20;

	// Matrix byte offset (slot times three) of each pixel position.
	localparam int PixelBase [SlotCount] = '{
		0, 30, 24, 6,
		15, 45, 39, 21,
		12, 42, 36, 18,
		3, 33, 27, 9
	};

	typedef struct {
		logic [7:0] slope;
		logic [7:0] offset;
		bit         flat;
		logic [7:0] flat_level;
	} directed_row_t;

	// Rows marked flat produce the same threshold in all 48 entries.
	directed_row_t directed_rows [DirectedRows] = '{
		'{8'd0,   8'd0,   1'b1, 8'd0},
		'{8'd0,   8'd255, 1'b1, 8'd255},
		'{8'd255, 8'd255, 1'b1, 8'd255},
		'{8'd0,   8'd128, 1'b1, 8'd128},
		'{8'd0,   8'd1,   1'b1, 8'd1},
		'{8'd255, 8'd0,   1'b0, 8'd0},
		'{8'd1,   8'd0,   1'b0, 8'd0},
		'{8'd85,  8'd0,   1'b0, 8'd0},
		'{8'd86,  8'd0,   1'b0, 8'd0},
		'{8'd128, 8'd0,   1'b0, 8'd0},
		'{8'd127, 8'd128, 1'b0, 8'd0},
		'{8'd16,  8'd16,  1'b0, 8'd0},
		'{8'd64,  8'd64,  1'b0, 8'd0},
		'{8'd170, 8'd85,  1'b0, 8'd0},
		'{8'd85,  8'd170, 1'b0, 8'd0},
		'{8'd1,   8'd254, 1'b0, 8'd0},
		'{8'd3,   8'd250, 1'b0, 8'd0},
		'{8'd15,  8'd0,   1'b0, 8'd0},
		'{8'd255, 8'd1,   1'b0, 8'd0},
		'{8'd100, 8'd200, 1'b0, 8'd0}
	};

	logic      clk;
	logic      arst_n = 1'b0;
	logic      start  = 1'b0;
	logic      busy;
	dtm_req_t  req    = '0;
	logic      result_valid;
	dtm_res_t  result;

	dtm_res_t  pending_thresholds [$];
	dtm_res_t  want;
	int unsigned mismatch_count = 0;
	int unsigned entries_seen   = 0;
	int unsigned requests_sent  = 0;
	int unsigned stall_cycles   = 0;

	dither_threshold_matrix_generator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req          (req),
		.result_valid (result_valid),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Expected 48 entries of one request, appended in index order.
	function automatic void compute_threshold_matrix(input dtm_req_t r);
		int unsigned lvl [LevelCount];
		logic [7:0]  thr [EntryCount];
		int unsigned v;
		int unsigned step;
		dtm_res_t    e;
		for (int k = 0; k < LevelCount; k++) begin
			v = int'(r.offset) + k * int'(r.slope);
			lvl[k] = (v < LevelLimit) ? v : int'(LevelMax);
		end
		for (int ch = 0; ch < ChanCount; ch++) begin
			step = lvl[ch + 1] - lvl[ch];
			for (int p = 0; p < SlotCount; p++) begin
				thr[ch + PixelBase[p]] = 8'(((lvl[ch] << 4) + p * step) >> 4);
			end
		end
		for (int i = 0; i < EntryCount; i++) begin
			e.entry_index = 6'(i);
			e.threshold   = thr[i];
			e.last_entry  = (i == EntryCount - 1);
			pending_thresholds.push_back(e);
		end
	endfunction

	// Returns at the edge where the transaction is accepted.
	task automatic issue_request(input dtm_req_t r);
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
		requests_sent++;
	endtask

	// With a chance of pct percent, drops start until the block is free and for a
	// random number of cycles after that, wiggling req meanwhile.
	task automatic hold_off_start(input int unsigned pct);
		if (pct != 0 && $urandom_range(99) < pct) begin
			start <= 1'b0;
			do begin
				req <= 16'($urandom);
				@(posedge clk);
			end while (busy || $urandom_range(99) < pct);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			entries_seen++;
			if (pending_thresholds.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected entry: index %0d threshold %0d last %0b",
					$time, result.entry_index, result.threshold, result.last_entry);
			end else begin
				want = pending_thresholds.pop_front();
				if (result.entry_index !== want.entry_index ||
				    result.threshold !== want.threshold ||
				    result.last_entry !== want.last_entry) begin
					mismatch_count++;
					$display("%0t: expected index %0d threshold %0d last %0b, got %0d %0d %0b",
						$time, want.entry_index, want.threshold, want.last_entry,
						result.entry_index, result.threshold, result.last_entry);
				end
			end
		end
	end

	// Watchdog: ends the run when nothing is accepted and no entry appears for too long.
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if ((start && !busy) || result_valid)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= StallLimit)
				break;
		end
		$display("%0t: no transaction for %0d cycles", $time, StallLimit);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		dtm_req_t    r;
		int unsigned idle_pct;
		int unsigned kind;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DirectedRows; i++) begin
			r.slope  = directed_rows[i].slope;
			r.offset = directed_rows[i].offset;
			issue_request(r);
			if (directed_rows[i].flat) begin
				for (int j = 0; j < EntryCount; j++)
					pending_thresholds.push_back('{6'(j), directed_rows[i].flat_level,
						j == EntryCount - 1});
			end else begin
				compute_threshold_matrix(r);
			end
		end

		// Three phases: back to back, sparse requests, moderate gaps.
		for (int i = 0; i < RandomCount; i++) begin
			idle_pct = (i < RandomCount / 3) ? 0 : (i < 2 * RandomCount / 3) ? 76 : 30;
			hold_off_start(idle_pct);
			kind = $urandom_range(9);
			if (kind < 5) begin
				r = 16'($urandom);
			end else if (kind < 7) begin
				r.slope  = 8'($urandom_range(15));
				r.offset = 8'($urandom);
			end else if (kind < 9) begin
				r.slope  = 8'($urandom);
				r.offset = 8'($urandom_range(255, 192));
			end else begin
				r.slope  = $urandom_range(1) ? LevelMax : 8'd0;
				r.offset = $urandom_range(1) ? LevelMax : 8'd0;
			end
			issue_request(r);
			compute_threshold_matrix(r);
		end
		start <= 1'b0;

		while (pending_thresholds.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		$display("Sent %0d requests (flat, saturating and random levels) and checked %0d entries.",
			requests_sent, entries_seen);
		$display("Mismatches: %0d", mismatch_count);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
